// ===== sv/sfl_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, codes and stage payload types for the spring force block.
package sfl_pkg;

    localparam int POS_W = 32;
    localparam int DIF_W = 33;
    localparam int SUM_W = 66;
    localparam int LEN_W = 33;
    localparam int RL_W  = 31;
    localparam int TOL_W = 16;
    localparam int BND_W = 32;
    localparam int ERR_W = 33;
    localparam int A_W   = 64;
    localparam int PP_W  = 65;
    localparam int NUM_W = 97;
    localparam int DIV_W = 49;
    localparam int Q_W   = 32;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd655;

    typedef enum logic [1:0] {
        ACT_FORCE = 2'd0,
        ACT_FULL  = 2'd1,
        ACT_TOL   = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef struct packed {
        logic [2:0][DIF_W-1:0] mag;
        logic [2:0]            dneg;
        t_action               action;
        logic [RL_W-1:0]       rest;
        logic [RL_W-1:0]       stiff;
    } t_sq_side;

    typedef struct packed {
        logic [2:0] neg;
        logic       kill;
        logic       degen;
    } t_dv_side;

endpackage

// ===== sv/spring_force_and_length_constraint.sv =====
`timescale 1ns / 1ps
// Spring force / length constraint top level: pipeline, tolerance register and output stage.
// Accepts one spring per cycle while not stalled and returns its first-endpoint vector
// after 3 difference/square/sum stages, 33 square-root stages, 6 bound and product
// stages, 32 divider stages and 1 output stage; the bit-per-stage square root and divider
// set most of that depth. All stages advance together and hold while a finished result
// is stalled. The tolerance register may be written at any time the pipeline is empty.
module spring_force_and_length_constraint
    import sfl_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [TOL_W-1:0]        i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_action,
    input  logic signed [POS_W-1:0] i_first_x,
    input  logic signed [POS_W-1:0] i_first_y,
    input  logic signed [POS_W-1:0] i_first_z,
    input  logic signed [POS_W-1:0] i_second_x,
    input  logic signed [POS_W-1:0] i_second_y,
    input  logic signed [POS_W-1:0] i_second_z,
    input  logic [RL_W-1:0]         i_rest_length,
    input  logic [RL_W-1:0]         i_stiffness,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [Q_W-1:0]   o_out_x,
    output logic signed [Q_W-1:0]   o_out_y,
    output logic signed [Q_W-1:0]   o_out_z,
    output logic                    o_applied,
    output logic                    o_degenerate
);

    logic en;
    logic [TOL_W-1:0] r_tol;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tol <= i_cfg_data;
        end
    end

    // stage A: differences and magnitudes
    logic [2:0][POS_W-1:0] pos_a, pos_b;
    t_sq_side n_a_side, r_a_side;
    logic r_a_vld;

    assign pos_a = {i_first_z, i_first_y, i_first_x};
    assign pos_b = {i_second_z, i_second_y, i_second_x};

    always_comb begin
        logic [DIF_W-1:0] d;
        n_a_side = '0;
        for (int i = 0; i < 3; i++) begin
            d = {pos_b[i][POS_W-1], pos_b[i]} - {pos_a[i][POS_W-1], pos_a[i]};
            n_a_side.dneg[i] = d[DIF_W-1];
            n_a_side.mag[i]  = d[DIF_W-1] ? DIF_W'(-d) : d;
        end
        n_a_side.action = t_action'(i_action);
        n_a_side.rest   = i_rest_length;
        n_a_side.stiff  = i_stiffness;
    end

    // stage B: squares, stage C: sum
    logic [2:0][SUM_W-1:0] r_b_sq;
    t_sq_side r_b_side, r_c_side;
    logic r_b_vld, r_c_vld;
    logic [SUM_W-1:0] r_c_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_side <= n_a_side;
            for (int i = 0; i < 3; i++) begin
                r_b_sq[i] <= SUM_W'(r_a_side.mag[i]) * SUM_W'(r_a_side.mag[i]);
            end
            r_b_side <= r_a_side;
            r_c_sum  <= r_b_sq[0] + r_b_sq[1] + r_b_sq[2];
            r_c_side <= r_b_side;
        end
    end

    logic sq_vld;
    logic [LEN_W-1:0] sq_root;
    t_sq_side sq_side;

    sfl_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c_vld),
        .i_sum   (r_c_sum),
        .i_side  (r_c_side),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // P1: tolerance bounds
    logic r_p1_vld;
    logic [LEN_W-1:0] r_p1_len;
    t_sq_side r_p1_side;
    logic [BND_W-1:0] r_p1_up, r_p1_lo;
    logic [47:0] prod_up, prod_lo;

    assign prod_up = 48'(sq_side.rest) * 48'({1'b0, r_tol} + 17'h10000);
    assign prod_lo = 48'(sq_side.rest) * 48'(17'h10000 - {1'b0, r_tol});

    // P2: bound selection and error
    logic r_p2_vld;
    logic [ERR_W-1:0] r_p2_emag;
    logic [DIV_W-1:0] r_p2_den;
    logic [2:0] r_p2_neg;
    logic r_p2_kill, r_p2_degen;
    t_sq_side r_p2_side;

    logic [LEN_W-1:0] bnd;
    logic inband, eneg;
    logic [ERR_W-1:0] emag;

    always_comb begin
        inband = 1'b0;
        bnd    = LEN_W'(r_p1_side.rest);
        if (r_p1_side.action == ACT_TOL) begin
            if (r_p1_len > LEN_W'(r_p1_up)) begin
                bnd = LEN_W'(r_p1_up);
            end else if (r_p1_len < LEN_W'(r_p1_lo)) begin
                bnd = LEN_W'(r_p1_lo);
            end else begin
                inband = 1'b1;
            end
        end
        eneg = r_p1_len < bnd;
        emag = eneg ? bnd - r_p1_len : r_p1_len - bnd;
    end

    // P3: stiffness scaling, P4: partial products, P5: numerator, P6: overflow check
    logic r_p3_vld, r_p4_vld, r_p5_vld, r_p6_vld;
    logic [A_W-1:0] r_p3_a;
    logic [2:0][PP_W-1:0] r_p4_lo, r_p4_hi;
    logic [2:0][NUM_W-1:0] r_p5_num;
    logic [2:0][DIF_W-1:0] r_p3_mag;
    logic [DIV_W-1:0] r_p3_den, r_p4_den, r_p5_den, r_p6_den;
    t_dv_side r_p3_dv, r_p4_dv, r_p5_dv, r_p6_dv;
    logic [2:0][DIV_W-1:0] r_p6_rem;
    logic [2:0][Q_W-1:0] r_p6_low;
    logic [2:0] r_p6_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
            r_p4_vld <= 1'b0;
            r_p5_vld <= 1'b0;
            r_p6_vld <= 1'b0;
        end else if (en) begin
            r_p1_vld <= sq_vld;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
            r_p4_vld <= r_p3_vld;
            r_p5_vld <= r_p4_vld;
            r_p6_vld <= r_p5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_len  <= sq_root;
            r_p1_side <= sq_side;
            r_p1_up   <= prod_up[47:16];
            r_p1_lo   <= prod_lo[47:16];

            r_p2_emag  <= emag;
            r_p2_den   <= (r_p1_side.action == ACT_FORCE) ? DIV_W'(r_p1_len) << 16
                                                          : DIV_W'(r_p1_len) << 1;
            r_p2_neg   <= {3{eneg}} ^ r_p1_side.dneg;
            r_p2_kill  <= (r_p1_side.action == ACT_NONE) || (r_p1_len == '0) || inband;
            r_p2_degen <= (r_p1_side.action != ACT_NONE) && (r_p1_len == '0);
            r_p2_side  <= r_p1_side;

            r_p3_a   <= (r_p2_side.action == ACT_FORCE) ?
                        A_W'(r_p2_side.stiff) * A_W'(r_p2_emag) : A_W'(r_p2_emag);
            r_p3_mag <= r_p2_side.mag;
            r_p3_den <= r_p2_den;
            r_p3_dv  <= '{neg: r_p2_neg, kill: r_p2_kill, degen: r_p2_degen};

            for (int i = 0; i < 3; i++) begin
                r_p4_lo[i] <= PP_W'(r_p3_a[31:0]) * PP_W'(r_p3_mag[i]);
                r_p4_hi[i] <= PP_W'(r_p3_a[63:32]) * PP_W'(r_p3_mag[i]);
                r_p5_num[i] <= NUM_W'(r_p4_lo[i]) + (NUM_W'(r_p4_hi[i]) << 32);
                r_p6_ovf[i] <= r_p5_num[i][NUM_W-1:32] >= (NUM_W - 32)'(r_p5_den);
                r_p6_rem[i] <= r_p5_num[i][32+DIV_W-1:32];
                r_p6_low[i] <= r_p5_num[i][31:0];
            end
            r_p4_den <= r_p3_den;
            r_p4_dv  <= r_p3_dv;
            r_p5_den <= r_p4_den;
            r_p5_dv  <= r_p4_dv;
            r_p6_den <= r_p5_den;
            r_p6_dv  <= r_p5_dv;
        end
    end

    logic dv_vld;
    logic [2:0][Q_W-1:0] dv_quo;
    logic [2:0] dv_ovf;
    t_dv_side dv_side;

    sfl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_p6_vld),
        .i_rem   (r_p6_rem),
        .i_low   (r_p6_low),
        .i_ovf   (r_p6_ovf),
        .i_den   (r_p6_den),
        .i_side  (r_p6_dv),
        .o_valid (dv_vld),
        .o_quo   (dv_quo),
        .o_ovf   (dv_ovf),
        .o_side  (dv_side)
    );

    // output stage: saturate, sign, flags
    logic [2:0][Q_W-1:0] n_out;
    logic r_o_vld;
    logic [2:0][Q_W-1:0] r_out;
    logic r_o_applied, r_o_degen;

    always_comb begin
        logic [Q_W-1:0] lim, qs;
        for (int i = 0; i < 3; i++) begin
            lim = dv_side.neg[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            qs  = (dv_ovf[i] || dv_quo[i] > lim) ? lim : dv_quo[i];
            n_out[i] = dv_side.kill ? '0 : (dv_side.neg[i] ? Q_W'(-qs) : qs);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out       <= n_out;
            r_o_applied <= (n_out[0] != '0) || (n_out[1] != '0) || (n_out[2] != '0);
            r_o_degen   <= dv_side.degen;
        end
    end

    assign en           = !(r_o_vld && i_stall);
    assign o_stall      = !en;
    assign o_valid      = r_o_vld;
    assign o_out_x      = r_out[0];
    assign o_out_y      = r_out[1];
    assign o_out_z      = r_out[2];
    assign o_applied    = r_o_applied;
    assign o_degenerate = r_o_degen;

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> !o_applied && o_out_x == 0 && o_out_y == 0 && o_out_z == 0)
        else $error("degenerate result carries a nonzero vector");

    a_applied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_applied == (o_out_x != 0 || o_out_y != 0 || o_out_z != 0))
        else $error("applied flag disagrees with vector");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a blocked result");

endmodule

// ===== sv/sfl_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
module sfl_sqrt
    import sfl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [SUM_W-1:0] i_sum,
    input  t_sq_side         i_side,
    output logic             o_valid,
    output logic [LEN_W-1:0] o_root,
    output t_sq_side         o_side
);

    localparam int STAGES = LEN_W;

    logic                r_vld  [STAGES];
    logic [SUM_W-1:0]    r_rem  [STAGES];
    logic [LEN_W-1:0]    r_root [STAGES];
    t_sq_side            r_side [STAGES];

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        localparam int B = STAGES - 1 - g;
        logic             cur_vld;
        logic [SUM_W-1:0] cur_rem;
        logic [LEN_W-1:0] cur_root;
        t_sq_side         cur_side;
        logic [SUM_W-1:0] trial;
        logic             fit;

        if (g == 0) begin : g_first
            assign cur_vld  = i_valid;
            assign cur_rem  = i_sum;
            assign cur_root = '0;
            assign cur_side = i_side;
        end else begin : g_next
            assign cur_vld  = r_vld[g-1];
            assign cur_rem  = r_rem[g-1];
            assign cur_root = r_root[g-1];
            assign cur_side = r_side[g-1];
        end

        assign trial = (SUM_W'(cur_root) << (B + 1)) + (SUM_W'(1) << (2 * B));
        assign fit   = cur_rem >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= cur_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= fit ? cur_rem - trial : cur_rem;
                r_root[g] <= cur_root | (LEN_W'(fit) << B);
                r_side[g] <= cur_side;
            end
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_root  = r_root[STAGES-1];
    assign o_side  = r_side[STAGES-1];

endmodule

// ===== sv/sfl_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
module sfl_div
    import sfl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [2:0][DIV_W-1:0] i_rem,
    input  logic [2:0][Q_W-1:0]   i_low,
    input  logic [2:0]            i_ovf,
    input  logic [DIV_W-1:0]      i_den,
    input  t_dv_side              i_side,
    output logic                  o_valid,
    output logic [2:0][Q_W-1:0]   o_quo,
    output logic [2:0]            o_ovf,
    output t_dv_side              o_side
);

    localparam int STAGES = Q_W;

    logic                  r_vld  [STAGES];
    logic [2:0][DIV_W-1:0] r_rem  [STAGES];
    logic [2:0][Q_W-1:0]   r_low  [STAGES];
    logic [2:0][Q_W-1:0]   r_quo  [STAGES];
    logic [2:0]            r_ovf  [STAGES];
    logic [DIV_W-1:0]      r_den  [STAGES];
    t_dv_side              r_side [STAGES];

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic                  cur_vld;
        logic [2:0][DIV_W-1:0] cur_rem;
        logic [2:0][Q_W-1:0]   cur_low;
        logic [2:0][Q_W-1:0]   cur_quo;
        logic [2:0]            cur_ovf;
        logic [DIV_W-1:0]      cur_den;
        t_dv_side              cur_side;
        logic [2:0][DIV_W-1:0] n_rem;
        logic [2:0][Q_W-1:0]   n_quo;

        if (g == 0) begin : g_first
            assign cur_vld  = i_valid;
            assign cur_rem  = i_rem;
            assign cur_low  = i_low;
            assign cur_quo  = '0;
            assign cur_ovf  = i_ovf;
            assign cur_den  = i_den;
            assign cur_side = i_side;
        end else begin : g_next
            assign cur_vld  = r_vld[g-1];
            assign cur_rem  = r_rem[g-1];
            assign cur_low  = r_low[g-1];
            assign cur_quo  = r_quo[g-1];
            assign cur_ovf  = r_ovf[g-1];
            assign cur_den  = r_den[g-1];
            assign cur_side = r_side[g-1];
        end

        always_comb begin
            logic [DIV_W:0] cat;
            logic           fit;
            for (int l = 0; l < 3; l++) begin
                cat      = {cur_rem[l], cur_low[l][Q_W-1]};
                fit      = cat >= {1'b0, cur_den};
                n_rem[l] = fit ? DIV_W'(cat - {1'b0, cur_den}) : DIV_W'(cat);
                n_quo[l] = {cur_quo[l][Q_W-2:0], fit};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= cur_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_quo[g]  <= n_quo;
                r_ovf[g]  <= cur_ovf;
                r_den[g]  <= cur_den;
                r_side[g] <= cur_side;
                for (int l = 0; l < 3; l++) begin
                    r_low[g][l] <= cur_low[l] << 1;
                end
            end
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_quo   = r_quo[STAGES-1];
    assign o_ovf   = r_ovf[STAGES-1];
    assign o_side  = r_side[STAGES-1];

endmodule
